/* rtl/core/four_lane_sync_word_aligner_defines.svh */
// Assertion macros for the aligner checker.
`ifndef FOUR_LANE_SYNC_WORD_ALIGNER_DEFINES_SVH
`define FOUR_LANE_SYNC_WORD_ALIGNER_DEFINES_SVH

// Check a property on every rising edge of clk outside reset.
`define FSWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define FSWA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/fswa_pkg.sv */
// Types and constants of the four-lane sync word aligner.
package fswa_pkg;

  localparam int LANES_DEF   = 4;
  localparam int RAW_BITS    = 32;
  localparam int WORD_BITS   = 12;
  localparam int ITEM_BITS   = 8;
  localparam int HIST_BITS   = 44;
  localparam int SYNC_BITS   = 36;
  localparam int EMIT_BITS   = 48;
  localparam int OUT_LANES   = 4;
  localparam int EMIT_BASE   = HIST_BITS - ITEM_BITS - WORD_BITS;

  localparam logic [WORD_BITS-1:0] WORD_ONES  = 12'hfff;
  localparam logic [WORD_BITS-1:0] WORD_ZERO  = 12'h000;
  localparam logic [SYNC_BITS-1:0] SYNC_PAT   = 36'h0_0000_0fff;
  localparam logic [EMIT_BITS-1:0] TRAIN_PAT  = 48'hfff0_0000_0001;

  typedef struct packed {
    logic [RAW_BITS-1:0] raw_word;
    logic                restart;
  } in_word_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] lane0_word;
    logic [WORD_BITS-1:0] lane1_word;
    logic [WORD_BITS-1:0] lane2_word;
    logic [WORD_BITS-1:0] lane3_word;
    logic [OUT_LANES-1:0] word_valid_mask;
    logic [OUT_LANES-1:0] found_mask;
    logic                 all_locked;
    logic [OUT_LANES-1:0] train_good_mask;
  } out_word_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 valid;
    logic                 found;
    logic                 good;
  } lane_stat_t;

endpackage

/* rtl/core/fswa_lane.sv */
// One lane: bit history, word boundary tracking, sync search and training check.
module fswa_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           advance,
  input  logic                           restart,
  input  logic                           frozen,
  input  logic [fswa_pkg::ITEM_BITS-1:0] lane_bits,
  output fswa_pkg::lane_stat_t           stat
);

  logic [fswa_pkg::HIST_BITS-1:0] hist_r, hist_cur, hist_nxt;
  logic [fswa_pkg::EMIT_BITS-1:0] emit_r, emit_cur, emit_nxt;
  logic [3:0]                     btb_r, btb_cur, btb_nxt;
  logic                           found_r, found_cur, found_nxt;
  logic                           good_r, good_cur, good_nxt;
  logic [fswa_pkg::WORD_BITS-1:0] word;
  logic                           word_valid;

  always_comb begin
    hist_cur  = restart ? '0 : hist_r;
    emit_cur  = restart ? '0 : emit_r;
    btb_cur   = restart ? '0 : btb_r;
    found_cur = restart ? 1'b0 : found_r;
    good_cur  = restart ? 1'b0 : good_r;

    // shift in the new bits on top, oldest drop off the bottom
    hist_nxt   = {lane_bits, hist_cur[fswa_pkg::HIST_BITS-1:fswa_pkg::ITEM_BITS]};
    emit_nxt   = emit_cur;
    btb_nxt    = btb_cur;
    found_nxt  = found_cur;
    good_nxt   = good_cur;
    word       = '0;
    word_valid = 1'b0;

    if (found_cur) begin
      if (btb_cur <= 4'(fswa_pkg::ITEM_BITS)) begin
        word = fswa_pkg::WORD_BITS'(hist_nxt >> (6'(btb_cur) + 6'(fswa_pkg::EMIT_BASE)));
        word_valid = 1'b1;
        if (emit_cur == fswa_pkg::TRAIN_PAT && word != fswa_pkg::WORD_ZERO &&
            word != fswa_pkg::WORD_ONES) begin
          good_nxt = 1'b1;
        end
        emit_nxt = {emit_cur[fswa_pkg::EMIT_BITS-fswa_pkg::WORD_BITS-1:0], word};
        btb_nxt  = btb_cur + 4'(fswa_pkg::WORD_BITS - fswa_pkg::ITEM_BITS);
      end else begin
        btb_nxt = btb_cur - 4'(fswa_pkg::ITEM_BITS);
      end
    end

    // search every phase unless frozen; the latest phase in time wins
    if (!frozen) begin
      for (int s = 1; s <= fswa_pkg::ITEM_BITS; s++) begin
        if (hist_nxt[s +: fswa_pkg::SYNC_BITS] == fswa_pkg::SYNC_PAT) begin
          btb_nxt   = 4'(fswa_pkg::WORD_BITS - fswa_pkg::ITEM_BITS + s);
          found_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      emit_r  <= '0;
      btb_r   <= '0;
      found_r <= 1'b0;
      good_r  <= 1'b0;
    end else if (advance) begin
      hist_r  <= hist_nxt;
      emit_r  <= emit_nxt;
      btb_r   <= btb_nxt;
      found_r <= found_nxt;
      good_r  <= good_nxt;
    end
  end

  assign stat.word  = word;
  assign stat.valid = word_valid;
  assign stat.found = found_nxt;
  assign stat.good  = good_nxt;

endmodule

/* rtl/core/four_lane_sync_word_aligner.sv */
// Top level of the four-lane sync word aligner.
//
//   channel  direction  payload               handshake
//   in_      input      fswa_pkg::in_word_t   in_valid, in_stall
//   out_     output     fswa_pkg::out_word_t  out_valid, out_stall
//
// One word per cycle while the result is not stalled; an accepted word passes
// through the input register, then the lane logic into the result register.
// The lanes work in parallel, each a single pass of shift, extract and an
// eight-phase sync compare. Reset (rst_n low, synchronous) clears all lane state.
// A stalled result holds; an empty input register still takes one more word,
// then in_stall stays high until the result moves on.
module four_lane_sync_word_aligner #(
  parameter int LANES = fswa_pkg::LANES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fswa_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fswa_pkg::out_word_t out_data
);

  logic                 in_valid_r;
  fswa_pkg::in_word_t   in_data_r;
  logic                 out_valid_r;
  fswa_pkg::out_word_t  out_data_r, out_data_nxt;
  logic                 frozen_r, frozen_cur, frozen_nxt;
  logic                 advance;

  logic [fswa_pkg::ITEM_BITS-1:0] lbits [LANES];
  fswa_pkg::lane_stat_t           stat  [LANES];
  logic [LANES-1:0]               found_vec;

  logic [fswa_pkg::WORD_BITS-1:0] words [fswa_pkg::OUT_LANES];
  logic [fswa_pkg::OUT_LANES-1:0] wv_mask, fd_mask, gd_mask;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // gather each lane's bits; positions past the capture word read as zero
  for (genvar l = 0; l < LANES; l++) begin : g_gather
    for (genvar i = 0; i < fswa_pkg::ITEM_BITS; i++) begin : g_bit
      if (l + LANES * i < fswa_pkg::RAW_BITS) begin : g_in
        assign lbits[l][i] = in_data_r.raw_word[l + LANES * i];
      end else begin : g_zero
        assign lbits[l][i] = 1'b0;
      end
    end
  end

  assign frozen_cur = in_data_r.restart ? 1'b0 : frozen_r;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    fswa_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .restart   (in_data_r.restart),
      .frozen    (frozen_cur),
      .lane_bits (lbits[l]),
      .stat      (stat[l])
    );
    assign found_vec[l] = stat[l].found;
  end

  assign frozen_nxt = &found_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frozen_r <= 1'b0;
    end else if (advance) begin
      frozen_r <= frozen_nxt;
    end
  end

  for (genvar l = 0; l < fswa_pkg::OUT_LANES; l++) begin : g_out
    if (l < LANES) begin : g_live
      assign words[l]   = stat[l].word;
      assign wv_mask[l] = stat[l].valid;
      assign fd_mask[l] = stat[l].found;
      assign gd_mask[l] = stat[l].good;
    end else begin : g_none
      assign words[l]   = '0;
      assign wv_mask[l] = 1'b0;
      assign fd_mask[l] = 1'b0;
      assign gd_mask[l] = 1'b0;
    end
  end

  always_comb begin
    out_data_nxt.lane0_word      = words[0];
    out_data_nxt.lane1_word      = words[1];
    out_data_nxt.lane2_word      = words[2];
    out_data_nxt.lane3_word      = words[3];
    out_data_nxt.word_valid_mask = wv_mask;
    out_data_nxt.found_mask      = fd_mask;
    out_data_nxt.all_locked      = frozen_nxt;
    out_data_nxt.train_good_mask = gd_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/fswa_checker.sv */
// Port-level checker for the four-lane sync word aligner, bound to the top level.
`include "four_lane_sync_word_aligner_defines.svh"

module fswa_checker #(
  parameter int LANES = fswa_pkg::LANES_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input fswa_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input fswa_pkg::out_word_t out_data
);

  localparam logic [fswa_pkg::OUT_LANES-1:0] ALL_MASK =
    (LANES >= fswa_pkg::OUT_LANES) ? {fswa_pkg::OUT_LANES{1'b1}} :
    fswa_pkg::OUT_LANES'((1 << LANES) - 1);

  // hold a stalled result
  `FSWA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // a lane emits only once it has been found
  `FSWA_ASSERT(a_valid_found, out_valid |-> ((out_data.word_valid_mask & ~out_data.found_mask) == '0), "word from a lane not found")

  // lock means every lane is found
  `FSWA_ASSERT(a_lock_all, (out_valid && out_data.all_locked) |-> (out_data.found_mask == ALL_MASK), "locked with a lane missing")

  // drop words of lanes that did not complete one
  `FSWA_ASSERT(a_word_zero, out_valid |-> ((out_data.word_valid_mask[0] || out_data.lane0_word == '0) && (out_data.word_valid_mask[1] || out_data.lane1_word == '0) && (out_data.word_valid_mask[2] || out_data.lane2_word == '0) && (out_data.word_valid_mask[3] || out_data.lane3_word == '0)), "word set without valid bit")

endmodule

bind four_lane_sync_word_aligner fswa_checker #(.LANES(LANES)) u_fswa_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the four-lane sync word aligner.
`timescale 1ns / 1ps

module tb_top;
  import fswa_pkg::*;

  localparam int LANES       = LANES_DEF;
  localparam int RANDOM_WORDS = 1650;
  localparam int STREAM_BITS = 512;
  localparam int CYCLE_LIMIT = 250000;
  localparam int LONG_HOLD   = 60;
  localparam int SHIFT_GAP   = WORD_BITS - ITEM_BITS;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;

  // Predictor state
  logic [HIST_BITS-1:0] lane_hist [LANES];
  logic [3:0]           lane_gap [LANES];
  logic [EMIT_BITS-1:0] train_hist [LANES];
  logic [LANES-1:0]     found_q;
  logic                 frozen_q;
  logic [LANES-1:0]     good_q;

  in_word_t    capture_words [$];
  out_word_t   expected_aligned [$];
  int unsigned total_words;
  int unsigned words_accepted = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          offer_live = 1'b0;
  bit          drain_pause = 1'b0;
  bit          pause_done = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Stimulus build area: per-lane bit streams, earliest bit at index 0
  logic [STREAM_BITS-1:0] lane_stream [LANES];
  int unsigned            lane_len [LANES];

  four_lane_sync_word_aligner i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_aligner();
    for (int l = 0; l < LANES; l++) begin
      lane_hist[l]  = '0;
      lane_gap[l]   = '0;
      train_hist[l] = '0;
    end
    found_q  = '0;
    frozen_q = 1'b0;
    good_q   = '0;
  endfunction

  function automatic out_word_t predict_aligned_word(in_word_t w);
    out_word_t            r;
    logic [WORD_BITS-1:0] lane_out [OUT_LANES];
    logic [LANES-1:0]     fresh;
    logic [LANES-1:0]     prior;
    logic [ITEM_BITS-1:0] slice;
    logic [HIST_BITS-1:0] h;
    logic [WORD_BITS-1:0] wd;
    int unsigned          gap;
    if (w.restart) clear_aligner();
    prior = found_q;
    fresh = '0;
    for (int l = 0; l < OUT_LANES; l++) lane_out[l] = '0;
    for (int l = 0; l < LANES; l++) begin
      for (int i = 0; i < ITEM_BITS; i++) begin
        slice[i] = (l + LANES * i < RAW_BITS) ? w.raw_word[l + LANES * i] : 1'b0;
      end
      h = {slice, lane_hist[l][HIST_BITS-1:ITEM_BITS]};
      lane_hist[l] = h;
      gap = lane_gap[l];
      if (prior[l]) begin
        if (gap <= ITEM_BITS) begin
          wd = WORD_BITS'(h >> (gap + EMIT_BASE));
          if (train_hist[l] == TRAIN_PAT && wd != WORD_ZERO && wd != WORD_ONES) good_q[l] = 1'b1;
          train_hist[l] = {train_hist[l][EMIT_BITS-WORD_BITS-1:0], wd};
          if (l < OUT_LANES) lane_out[l] = wd;
          fresh[l] = 1'b1;
          gap = gap + SHIFT_GAP;
        end else begin
          gap = gap - ITEM_BITS;
        end
      end
      // Search all eight new phases unless frozen; the latest match wins
      if (!frozen_q) begin
        for (int s = 1; s <= ITEM_BITS; s++) begin
          if (h[s +: SYNC_BITS] == SYNC_PAT) begin
            gap = SHIFT_GAP + s;
            found_q[l] = 1'b1;
          end
        end
      end
      lane_gap[l] = gap[3:0];
    end
    if (&found_q) frozen_q = 1'b1;
    r.lane0_word      = lane_out[0];
    r.lane1_word      = lane_out[1];
    r.lane2_word      = lane_out[2];
    r.lane3_word      = lane_out[3];
    r.word_valid_mask = OUT_LANES'(fresh);
    r.found_mask      = OUT_LANES'(found_q);
    r.all_locked      = frozen_q;
    r.train_good_mask = OUT_LANES'(good_q);
    return r;
  endfunction

  task automatic push_bits(int l, logic [63:0] bits, int n);
    for (int i = 0; i < n; i++) begin
      lane_stream[l][lane_len[l]] = bits[i];
      lane_len[l]++;
    end
  endtask

  task automatic push_sync(int l, bit corrupt);
    push_bits(l, 64'(WORD_ONES), WORD_BITS);
    push_bits(l, 64'h0, 2 * WORD_BITS);
    // Flip one bit of the pattern to make a near miss
    if (corrupt) lane_stream[l][lane_len[l] - 1 - $urandom_range(SYNC_BITS - 1)] ^= 1'b1;
  endtask

  // Queue words with a sync, a training word and data per lane, exact only if clean
  task automatic queue_sync_burst(bit with_restart, bit clean);
    int unsigned          longest;
    int unsigned          n_words;
    int unsigned          idx;
    logic [WORD_BITS-1:0] follower;
    in_word_t             w;
    longest = 0;
    for (int l = 0; l < LANES; l++) begin
      lane_len[l] = 0;
      lane_stream[l] = '0;
      if (!clean) begin
        push_bits(l, {$urandom, $urandom}, $urandom_range(0, 23));
        if ($urandom_range(3) == 0) begin
          push_sync(l, 1'b0);
          push_bits(l, 64'($urandom), $urandom_range(0, 15));
        end
      end
      push_sync(l, !clean && $urandom_range(7) == 0);
      push_bits(l, (clean || $urandom_range(7) != 0) ? 64'h001 : 64'($urandom), WORD_BITS);
      case ($urandom_range(5))
        0: follower = WORD_ZERO;
        1: follower = WORD_ONES;
        default: follower = WORD_BITS'($urandom_range(1, 32'hffe));
      endcase
      if (clean) follower = WORD_BITS'($urandom_range(1, 32'hffe));
      push_bits(l, 64'(follower), WORD_BITS);
      push_bits(l, {$urandom, $urandom}, WORD_BITS * $urandom_range(2, 5));
      if (lane_len[l] > longest) longest = lane_len[l];
    end
    n_words = (longest + ITEM_BITS - 1) / ITEM_BITS + 1;
    for (int k = 0; k < n_words; k++) begin
      w.restart = with_restart && k == 0;
      for (int l = 0; l < LANES; l++) begin
        for (int i = 0; i < ITEM_BITS; i++) begin
          idx = k * ITEM_BITS + i;
          w.raw_word[l + LANES * i] = (idx < lane_len[l]) ? lane_stream[l][idx] : 1'($urandom);
        end
      end
      capture_words.insert(capture_words.size(), w);
    end
  endtask

  task automatic queue_word(logic [RAW_BITS-1:0] raw, bit restart);
    in_word_t w;
    w.raw_word = raw;
    w.restart  = restart;
    capture_words.insert(capture_words.size(), w);
  endtask

  function automatic int unsigned idle_pct(bit sender);
    if (words_accepted < total_words / 3) return sender ? 11 : 77;
    if (words_accepted < 2 * total_words / 3) return sender ? 77 : 11;
    return 0;
  endfunction

  task automatic log_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) log_error($sformatf("%s: expected %0h, got %0h", name, want, got));
  endtask

  // Sender: hold a stalled word, otherwise offer the next one or idle
  always @(negedge clk) begin
    if (rst_n && !offer_live) begin
      if (!pause_done && words_accepted >= total_words / 2) begin
        drain_pause = 1'b1;
        pause_done  = 1'b1;
      end
      if (drain_pause && expected_aligned.size() == 0) drain_pause = 1'b0;
      if (!drain_pause && capture_words.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
        in_data    <= capture_words.pop_front();
        in_valid   <= 1'b1;
        offer_live  = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && words_accepted >= 5 * total_words / 6) begin
      hold_done  = 1'b1;
      hold_left  = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct(1'b0));
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_aligned.insert(expected_aligned.size(), predict_aligned_word(in_data));
        words_accepted++;
        offer_live = 1'b0;
      end
      if (out_valid && !out_stall) begin
        if (expected_aligned.size() == 0) begin
          log_error($sformatf("result %h with nothing outstanding", out_data));
        end else begin
          want = expected_aligned.pop_front();
          cmp_field("lane0_word", want.lane0_word, out_data.lane0_word);
          cmp_field("lane1_word", want.lane1_word, out_data.lane1_word);
          cmp_field("lane2_word", want.lane2_word, out_data.lane2_word);
          cmp_field("lane3_word", want.lane3_word, out_data.lane3_word);
          cmp_field("word_valid_mask", want.word_valid_mask, out_data.word_valid_mask);
          cmp_field("found_mask", want.found_mask, out_data.found_mask);
          cmp_field("all_locked", want.all_locked, out_data.all_locked);
          cmp_field("train_good_mask", want.train_good_mask, out_data.train_good_mask);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned directed_words;
    int unsigned pick;
    clear_aligner();

    // Directed: field extremes, restart, then a clean lock with training on all lanes
    queue_word('0, 1'b1);
    queue_word('1, 1'b0);
    queue_word('0, 1'b0);
    queue_word(32'haaaa_aaaa, 1'b1);
    queue_word(32'h5555_5555, 1'b0);
    queue_sync_burst(1'b1, 1'b1);
    queue_word('1, 1'b1);
    directed_words = capture_words.size();

    // Random: mostly sync bursts with random content, some noise
    while (capture_words.size() < directed_words + RANDOM_WORDS) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        queue_sync_burst($urandom_range(3) != 0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(7))
            0: queue_word('0, $urandom_range(9) == 0);
            1: queue_word('1, $urandom_range(9) == 0);
            default: queue_word($urandom, $urandom_range(9) == 0);
          endcase
        end
      end
    end
    total_words = capture_words.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (words_accepted < total_words || expected_aligned.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/fswa_pkg.sv
rtl/core/fswa_lane.sv
rtl/core/four_lane_sync_word_aligner.sv
rtl/core/fswa_checker.sv
tb/tb_top.sv
